// ===== hw/rtl/wppq_pkg.sv =====
// ----------------------------------------------------------------------------
// Window peak picker package
// Shared constants, types and the sequencer state encoding.
// ----------------------------------------------------------------------------
package wppq_pkg;

	localparam int unsigned MaxPoints     = 1024;
	localparam int unsigned MzW           = 32;
	localparam int unsigned StepW         = 16;
	localparam logic [15:0] GridStepReset = 16'd6554;

	localparam logic CmdLoad  = 1'b0;
	localparam logic CmdQuery = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_SCAN,
		ST_NB_RD0,
		ST_NB_RD1,
		ST_NB_RD2,
		ST_NB_EVAL,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	// Divider handshake between the top level and the serial divider.
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== hw/rtl/wppq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module wppq_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] store_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[addr] <= wdata;
		end
		rdata <= store_q[addr];
	end

endmodule

// ===== hw/rtl/wppq_div.sv =====
// ----------------------------------------------------------------------------
// Serial rounding divider
// Restoring division, one quotient bit per cycle, of a 49-bit magnitude by a
// 35-bit magnitude, giving floor((2*num + den) / (2*den)).
// ----------------------------------------------------------------------------
module wppq_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wppq_pkg::div_ctl_t   ctl,
	input  logic [48:0]          num,
	input  logic [34:0]          den,
	output wppq_pkg::div_sts_t   sts,
	output logic [49:0]          quot
);

	localparam int unsigned NW = 51;
	localparam int unsigned DW = 36;

	logic [NW-1:0] dividend_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] divisor_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted = {rem_q[DW-1:0], dividend_q[NW-1]};
	assign trial   = shifted - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			// Numerator 2*|n| + |2d|, divisor 2*|2d|.
			dividend_q <= {1'b0, num, 1'b0} + NW'(den);
			divisor_q  <= {den, 1'b0};
			rem_q      <= '0;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q      <= trial;
				dividend_q <= {dividend_q[NW-2:0], 1'b1};
			end else begin
				rem_q      <= shifted;
				dividend_q <= {dividend_q[NW-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot     = dividend_q[49:0];

endmodule

// ===== hw/rtl/window_peak_pick_quadratic.sv =====
// ----------------------------------------------------------------------------
// Window peak picker with three-point parabolic refinement
//
// The input channel (valid, stall) carries one word per command. A load word
// (cmd low) appends point_mz and point_level to the profile store and sets
// load_busy_q to hold off the next word; first_point empties the profile first.
// A query word (cmd high) scans the store from its first point, one point per
// ST_RD/ST_SCAN pair, up to the first point above window_high; for a hit with
// two neighbors it reads them and, where the fit applies, forms the refinement
// numerator with one multiply and runs the serial divider. The scan through
// the single RAM read port and the bit-serial divider set a query's length.
// The block takes no new word while a command is in flight.
// The result word sits in an output register; while the receiver stalls it
// holds, and the block accepts the next word only once the result is taken.
// Reset empties the profile, clears the overflow flag and sets grid_step to
// its default; the stores themselves are not cleared.
// The user writes grid_step via cfg_we/cfg_data only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module window_peak_pick_quadratic #(
	parameter int unsigned MaxPoints = wppq_pkg::MaxPoints
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic        first_point,
	input  logic [31:0] point_mz,
	input  logic [31:0] point_level,
	input  logic [31:0] window_low,
	input  logic [31:0] window_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] peak_mz,
	output logic [31:0] peak_level,
	output logic        points_dropped
);

	localparam int unsigned AW = $clog2(MaxPoints);
	localparam int unsigned CW = AW + 1;

	wppq_pkg::state_t state_q, state_d;

	logic [15:0]   step_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] best_q;
	logic [31:0]   best_lvl_q;
	logic          hit_q;
	logic [31:0]   lo_q, hi_q;
	logic [31:0]   x1_q, x2_q, y1_q, y3_q;
	logic [34:0]   d_q;
	logic          n_neg_q, d_neg_q;
	logic [48:0]   an_q;
	logic          load_busy_q;
	logic          out_valid_q;
	logic          found_q;
	logic [31:0]   peak_mz_q, peak_lvl_q;

	// Raw mz of the chosen point, captured during the scan; x2_sel_q marks a
	// refined value in x2_q.
	logic [31:0]   mz_at_best_q;
	logic          x2_sel_q;

	logic          we;
	logic [AW-1:0] addr;
	logic [31:0]   mz_rd, lvl_rd;
	logic          accept;
	logic signed [34:0] dd_c;

	wppq_pkg::div_ctl_t div_ctl;
	wppq_pkg::div_sts_t div_sts;
	logic [49:0]        quot;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != wppq_pkg::ST_IDLE) || load_busy_q || out_valid_q;

	// Parabola denominator 2*y2 - y1 - y3, with y3 on the read port.
	assign dd_c = $signed({2'b0, best_lvl_q, 1'b0}) - $signed({3'b0, y1_q}) -
	              $signed({3'b0, lvl_rd});

	// Loads write at the fill count, or at zero with first_point; a full store drops the point.
	always_comb begin
		logic [CW-1:0] base;
		base = first_point ? '0 : count_q;
		we   = accept && (cmd == wppq_pkg::CmdLoad) && (base < CW'(MaxPoints));
		addr = we ? base[AW-1:0] : idx_q[AW-1:0];
	end

	wppq_ram #(.Width(32), .Depth(MaxPoints)) u_mz_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(point_mz), .rdata(mz_rd)
	);

	wppq_ram #(.Width(32), .Depth(MaxPoints)) u_lvl_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(point_level), .rdata(lvl_rd)
	);

	wppq_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .num(an_q), .den(d_q),
		.sts(div_sts), .quot(quot)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wppq_pkg::ST_IDLE: begin
				if (accept && cmd == wppq_pkg::CmdQuery) begin
					state_d = wppq_pkg::ST_RD;
				end
			end
			wppq_pkg::ST_RD: begin
				state_d = (idx_q < count_q) ? wppq_pkg::ST_SCAN : wppq_pkg::ST_NB_RD0;
			end
			wppq_pkg::ST_SCAN: begin
				state_d = (mz_rd > hi_q) ? wppq_pkg::ST_NB_RD0 : wppq_pkg::ST_RD;
			end
			wppq_pkg::ST_NB_RD0: begin
				if (!hit_q || best_q == '0 || CW'(best_q) + CW'(1) >= count_q ||
				    step_q == '0) begin
					state_d = wppq_pkg::ST_OUT;
				end else begin
					state_d = wppq_pkg::ST_NB_RD1;
				end
			end
			wppq_pkg::ST_NB_RD1:  state_d = wppq_pkg::ST_NB_RD2;
			wppq_pkg::ST_NB_RD2:  state_d = wppq_pkg::ST_NB_EVAL;
			wppq_pkg::ST_NB_EVAL: begin
				state_d = wppq_pkg::ST_OUT;
				if ({2'b0, x1_q} + {1'b0, step_q, 1'b0} > {2'b0, x2_q} &&
				    {2'b0, mz_rd} < {2'b0, x2_q} + {17'b0, step_q, 1'b0} &&
				    dd_c != '0) begin
					state_d = wppq_pkg::ST_MUL;
				end
			end
			wppq_pkg::ST_MUL: state_d = wppq_pkg::ST_DIV;
			wppq_pkg::ST_DIV: if (div_sts.done) state_d = wppq_pkg::ST_FIN;
			wppq_pkg::ST_FIN: state_d = wppq_pkg::ST_OUT;
			wppq_pkg::ST_OUT: state_d = wppq_pkg::ST_IDLE;
			default:          state_d = wppq_pkg::ST_IDLE;
		endcase
	end

	// Output decode: the divider starts once the product is registered.
	always_comb begin
		div_ctl.start = (state_q == wppq_pkg::ST_DIV) && !div_sts.busy && !div_sts.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wppq_pkg::ST_IDLE;
			step_q      <= wppq_pkg::GridStepReset;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			load_busy_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			load_busy_q <= accept && cmd == wppq_pkg::CmdLoad;
			if (cfg_we) begin
				step_q <= cfg_data;
			end
			if (accept && cmd == wppq_pkg::CmdLoad) begin
				if (we) begin
					count_q <= (first_point ? '0 : count_q) + CW'(1);
					if (first_point) ovf_q <= 1'b0;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == wppq_pkg::ST_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		logic signed [33:0] diff;
		logic signed [34:0] tmp;
		logic signed [51:0] r;
		diff = '0;
		tmp  = '0;
		r    = '0;
		case (state_q)
			wppq_pkg::ST_IDLE: begin
				if (accept) begin
					lo_q       <= window_low;
					hi_q       <= window_high;
					idx_q      <= '0;
					hit_q      <= 1'b0;
					best_lvl_q <= '0;
					best_q     <= '0;
				end
			end
			wppq_pkg::ST_SCAN: begin
				if (mz_rd <= hi_q && mz_rd > lo_q && lvl_rd > best_lvl_q) begin
					best_lvl_q <= lvl_rd;
					best_q     <= idx_q[AW-1:0];
					hit_q      <= 1'b1;
				end
				idx_q <= idx_q + CW'(1);
			end
			wppq_pkg::ST_NB_RD0: begin
				idx_q <= CW'(best_q) - CW'(1);
			end
			wppq_pkg::ST_NB_RD1: begin
				idx_q <= CW'(best_q) + CW'(1);
			end
			wppq_pkg::ST_NB_RD2: begin
				x1_q <= mz_rd;
				y1_q <= lvl_rd;
				x2_q <= mz_at_best_q;
			end
			wppq_pkg::ST_NB_EVAL: begin
				y3_q    <= lvl_rd;
				d_neg_q <= dd_c[34];
				tmp     = dd_c[34] ? -dd_c : dd_c;
				d_q     <= tmp <<< 1;
			end
			wppq_pkg::ST_MUL: begin
				// |y3 - y1| times grid_step.
				diff = $signed({2'b0, y3_q}) - $signed({2'b0, y1_q});
				n_neg_q <= diff[33];
				an_q <= 49'(diff[33] ? 33'(-diff) : 33'(diff)) * 49'(step_q);
			end
			wppq_pkg::ST_FIN: begin
				if (n_neg_q != d_neg_q && an_q != '0) begin
					r = $signed({20'b0, x2_q}) - $signed({2'b0, quot});
				end else begin
					r = $signed({20'b0, x2_q}) + $signed({2'b0, quot});
				end
				if (r < 0) x2_q <= '0;
				else if (r > 52'sh0_0000_FFFF_FFFF) x2_q <= '1;
				else x2_q <= r[31:0];
			end
			default: begin
			end
		endcase
		if (state_q == wppq_pkg::ST_OUT) begin
			found_q    <= hit_q;
			peak_lvl_q <= hit_q ? best_lvl_q : '0;
			if (!hit_q) peak_mz_q <= '0;
			else if (best_q == '0 || CW'(best_q) + CW'(1) >= count_q ||
			         step_q == '0) peak_mz_q <= mz_at_best_q;
			else peak_mz_q <= x2_sel_q ? x2_q : mz_at_best_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wppq_pkg::ST_SCAN && mz_rd <= hi_q && mz_rd > lo_q &&
		    lvl_rd > best_lvl_q) begin
			mz_at_best_q <= mz_rd;
		end
		if (state_q == wppq_pkg::ST_RD) begin
			x2_sel_q <= 1'b0;
		end else if (state_q == wppq_pkg::ST_FIN) begin
			x2_sel_q <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign peak_mz        = peak_mz_q;
	assign peak_level     = peak_lvl_q;
	assign points_dropped = ovf_q;

endmodule

// ===== hw/rtl/wppq_checker.sv =====
// ----------------------------------------------------------------------------
// Window peak picker port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
module wppq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        found,
	input logic [31:0] peak_mz,
	input logic [31:0] peak_level
);

	// A result word without a hit carries zeros.
	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> peak_mz == '0 && peak_level == '0)
		else $error("miss result not zero");

	// A hit always has a positive level.
	a_hit_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> peak_level != '0)
		else $error("hit with zero level");

	// No word is taken while a result waits.
	a_hold_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");

	// A stalled result stays valid and holds peak_mz and found.
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(peak_mz) && $stable(found))
		else $error("stalled result changed");

endmodule

bind window_peak_pick_quadratic wppq_checker u_wppq_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .found(found),
	.peak_mz(peak_mz), .peak_level(peak_level)
);
